[design/bhcdc_pkg.sv]
// Shared types, constants and lookup functions for the hall commutation block.
package bhcdc_pkg;

	localparam int DUTY_BITS_DEF = 10;

	localparam logic OP_HALL = 1'b0;
	localparam logic OP_REV  = 1'b1;

	localparam logic [1:0] REG_TARGET_REVS     = 2'd0;
	localparam logic [1:0] REG_TARGET_VELOCITY = 2'd1;
	localparam logic [1:0] REG_REVERSE         = 2'd2;
	localparam logic [1:0] REG_ROTOR_ORIGIN    = 2'd3;

	localparam logic [15:0] TARGET_VELOCITY_RST = 16'd4608;
	localparam logic [16:0] REV_MAX             = 17'd131071;

	localparam int          RECIP_BITS = 28;
	localparam int          RECIP_CW   = $clog2(RECIP_BITS);
	localparam logic [RECIP_BITS-1:0] RECIP_NUM = RECIP_BITS'(256000000);

	localparam int          DIV100_SHIFT = 24;
	localparam logic [17:0] DIV100_MUL   = 18'd167773;

	localparam logic [5:0] DRIVE_MAP [8] = '{6'h12, 6'h18, 6'h09, 6'h21,
		6'h24, 6'h06, 6'h00, 6'h00};
	localparam logic [2:0] HALL_MAP [8] = '{3'd7, 3'd5, 3'd3, 3'd4,
		3'd1, 3'd0, 3'd2, 3'd7};

	typedef struct packed {
		logic        opcode;
		logic [2:0]  hall_bits;
		logic [31:0] time_us;
	} in_t;

	typedef struct packed {
		logic [2:0]  drive_state;
		logic [2:0]  low_side_on;
		logic [2:0]  high_side_on;
		logic [10:0] duty;
	} out_t;

	function automatic logic [2:0] drive_index(logic [2:0] rotor, logic [2:0] origin,
		logic rev);
		logic signed [5:0] sum;
		logic signed [5:0] red;
		sum = $signed({3'b000, rotor}) - $signed({3'b000, origin})
			+ (rev ? -6'sd2 : 6'sd2) + 6'sd6;
		if (sum >= 6'sd12) begin
			red = sum - 6'sd12;
		end else if (sum >= 6'sd6) begin
			red = sum - 6'sd6;
		end else begin
			red = sum;
		end
		return red[2:0];
	endfunction

	function automatic logic [2:0] low_mask(logic [5:0] pat);
		return {pat[4], pat[2], pat[0]};
	endfunction

	function automatic logic [2:0] high_mask(logic [5:0] pat);
		return {pat[5], pat[3], pat[1]};
	endfunction

endpackage

[design/bhcdc_recip.sv]
// Bit-serial restoring divider for the reciprocal pulse period, saturated to 16 bits.
module bhcdc_recip import bhcdc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [15:0] quotient
);

	logic                  run_q;
	logic                  done_q;
	logic [RECIP_CW-1:0]   cnt_q;
	logic [RECIP_BITS-1:0] num_q;
	logic [RECIP_BITS-1:0] quo_q;
	logic [31:0]           rem_q;
	logic [31:0]           dvs_q;
	logic [32:0]           trial;
	logic [32:0]           diff;
	logic                  fits;

	assign trial = {rem_q, num_q[RECIP_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + RECIP_CW'(1);
				if (cnt_q == RECIP_CW'(RECIP_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			num_q <= RECIP_NUM;
			rem_q <= '0;
			quo_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[RECIP_BITS-2:0], 1'b0};
			quo_q <= {quo_q[RECIP_BITS-2:0], fits};
			rem_q <= fits ? diff[31:0] : trial[31:0];
		end
	end

	assign done     = done_q;
	assign quotient = (|quo_q[RECIP_BITS-1:16]) ? 16'hFFFF : quo_q[15:0];

endmodule

[design/bhcdc_duty.sv]
// Four-stage duty limiter: position and velocity terms, clamp, minimum.
module bhcdc_duty import bhcdc_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] target_revs,
	input  logic [15:0] target_velocity,
	input  logic [16:0] rev_count,
	input  logic [15:0] velocity,
	output logic        done,
	output logic [10:0] duty
);

	localparam int          DW   = DUTY_BITS + 1;
	localparam int          SH   = DUTY_BITS - 8;
	localparam logic [DW-1:0] FULL = DW'(1) << DUTY_BITS;
	localparam logic [DW-1:0] LOW  = DW'((1 << DUTY_BITS) / 10);

	function automatic logic [DW-1:0] clamp_term(logic signed [35:0] q);
		logic [DW-1:0] t;
		t = DW'(q[7:0]) << SH;
		if (q >= 36'sd256) begin
			return FULL;
		end else if (q <= 36'sd0) begin
			return LOW;
		end else begin
			return (t < LOW) ? LOW : t;
		end
	endfunction

	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [33:0]              prod_s1;
	logic signed [17:0]       s_s1;
	logic [21:0]              v35_s1;
	logic signed [16:0]       wdif_s1;
	logic signed [31:0]       a_s2;
	logic signed [20:0]       w_s2;
	logic signed [35:0]       r_s3;
	logic [DW-1:0]            dw_s3;
	logic [DW-1:0]            duty_s4;
	logic [31:0]              k1;
	logic signed [31:0]       s_ext;
	logic signed [35:0]       a_ext;
	logic signed [20:0]       wd_ext;
	logic [DW-1:0]            dr;

	assign k1     = {22'b0, prod_s1[33:DIV100_SHIFT]} + 32'd1;
	assign s_ext  = 32'(s_s1);
	assign a_ext  = 36'(a_s2);
	assign wd_ext = 21'(wdif_s1);
	assign dr     = clamp_term(r_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			prod_s1 <= 34'(target_revs) * 34'(DIV100_MUL);
			s_s1    <= $signed({2'b00, target_revs}) - $signed({1'b0, rev_count});
			v35_s1  <= 22'(velocity) * 22'd35;
			wdif_s1 <= $signed({1'b0, target_velocity}) - $signed({1'b0, velocity});
		end
		if (v_s1) begin
			a_s2 <= (s_ext <<< 11) + (s_ext <<< 9) - $signed(32'(v35_s1))
				+ $signed(k1 << 8);
			w_s2 <= (wd_ext <<< 3) + (wd_ext <<< 1);
		end
		if (v_s2) begin
			r_s3  <= (a_ext <<< 2) + a_ext;
			dw_s3 <= clamp_term(36'(w_s2));
		end
		if (v_s3) begin
			duty_s4 <= (dr < dw_s3) ? dr : dw_s3;
		end
	end

	assign done = v_s4;
	assign duty = 11'(duty_s4);

endmodule

[design/bldc_hall_commutation_duty_control.sv]
// Top level: hall commutation with duty limiter and revolution velocity tracking.
//
//   channel  direction  handshake              payload
//   in       request    in_valid / in_ready    in_data  (in_t)
//   out      result     out_valid / out_ready  out_data (out_t)
//   cfg      write      cfg_we                 cfg_index, cfg_data
//
// A hall request that yields no result leaves the block ready for the next request; one that
// yields a result waits for the four-stage duty pipeline and then passes through the output register.
// A revolution request holds off new requests until the one-bit-per-cycle divider is done.
// Reset clears all rotor, count, period and velocity state and loads register defaults.
// A stalled result holds in the output register; the next request is still taken,
// and a following result waits in its own holding register until the output frees.
module bldc_hall_commutation_duty_control import bhcdc_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DUTY, ST_EMIT} state_t;

	state_t      state_q;
	logic [15:0] target_revs_q;
	logic [15:0] target_velocity_q;
	logic        reverse_q;
	logic [2:0]  rotor_origin_q;
	logic [2:0]  last_rotor_q;
	logic [16:0] rev_count_q;
	logic [31:0] last_pulse_q;
	logic [15:0] velocity_q;
	logic        out_valid_q;
	out_t        out_q;
	out_t        pend_q;

	logic        accept;
	logic [2:0]  rotor;
	logic [2:0]  idx;
	logic [5:0]  pat;
	logic        hall_fire;
	logic        div_start;
	logic        duty_start;
	logic        div_done;
	logic [15:0] div_quo;
	logic        duty_done;
	logic [10:0] duty_val;
	logic        emit;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign rotor      = HALL_MAP[in_data.hall_bits];
	assign idx        = drive_index(rotor, rotor_origin_q, reverse_q);
	assign pat        = DRIVE_MAP[idx];
	assign hall_fire  = (rev_count_q <= {1'b0, target_revs_q}) && (rotor != last_rotor_q);
	assign div_start  = accept && (in_data.opcode == OP_REV);
	assign duty_start = accept && (in_data.opcode == OP_HALL) && hall_fire;
	assign emit       = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	bhcdc_recip u_recip (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (in_data.time_us - last_pulse_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	bhcdc_duty #(
		.DUTY_BITS (DUTY_BITS)
	) u_duty (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (duty_start),
		.target_revs     (target_revs_q),
		.target_velocity (target_velocity_q),
		.rev_count       (rev_count_q),
		.velocity        (velocity_q),
		.done            (duty_done),
		.duty            (duty_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_revs_q     <= '0;
			target_velocity_q <= TARGET_VELOCITY_RST;
			reverse_q         <= 1'b1;
			rotor_origin_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_REVS:     target_revs_q     <= cfg_data;
				REG_TARGET_VELOCITY: target_velocity_q <= cfg_data;
				REG_REVERSE:         reverse_q         <= cfg_data[0];
				REG_ROTOR_ORIGIN:    rotor_origin_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			last_rotor_q <= '0;
			rev_count_q  <= '0;
			last_pulse_q <= '0;
			velocity_q   <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (div_start) begin
						last_pulse_q <= in_data.time_us;
						if (rev_count_q != REV_MAX) begin
							rev_count_q <= rev_count_q + 17'd1;
						end
						state_q <= ST_DIV;
					end else if (duty_start) begin
						last_rotor_q        <= rotor;
						pend_q.drive_state  <= idx;
						pend_q.low_side_on  <= low_mask(pat);
						pend_q.high_side_on <= high_mask(pat);
						state_q             <= ST_DUTY;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						velocity_q <= div_quo;
						state_q    <= ST_IDLE;
					end
				end
				ST_DUTY: begin
					if (duty_done) begin
						pend_q.duty <= duty_val;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						out_q   <= pend_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
